[design/leb_pkg.sv]
// Shared types and constants for the line edit buffer.
// No dependencies.
package leb_pkg;

    localparam int LINE_LEN = 128;
    localparam int IDX_W    = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int CUR_W    = $clog2(LINE_LEN + 1);
    localparam int CHAR_W   = 8;
    localparam int REQ_W    = 3;
    localparam int PEEK_W   = 7;
    localparam int CUROUT_W = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BACKSPACE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LEFT      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RIGHT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_IDLE      = 3'd6;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [LINE_LEN-1:0] line_t;

    typedef struct packed {
        logic ins;
        logic bs;
        logic del;
        logic clr;
    } edit_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [CUR_W-1:0] cursor;
    } peek_req_t;

endpackage

[design/leb_cell.sv]
// One byte of the line: holds, shifts from a neighbor, inserts or clears.
// Depends on leb_pkg.
module leb_cell
    import leb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  edit_ctl_t        ctl,
    input  logic [IDX_W-1:0] pos,
    input  logic [CUR_W-1:0] cursor,
    input  char_t            char_in,
    input  char_t            left_char,
    input  char_t            right_char,
    output char_t            data
);

    char_t            data_reg;
    char_t            data_next;
    logic [CUR_W-1:0] pos_ext;
    logic [CUR_W-1:0] pos_inc;

    assign pos_ext = CUR_W'(pos);
    assign pos_inc = pos_ext + CUR_W'(1);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.clr)
        begin
            data_next = '0;
        end
        else if (ctl.ins)
        begin
            if (pos_ext == cursor)
            begin
                data_next = char_in;
            end
            else if (pos_ext > cursor)
            begin
                data_next = left_char;
            end
        end
        else if (ctl.bs)
        begin
            if ((cursor != '0) && (pos_inc >= cursor))
            begin
                data_next = right_char;
            end
        end
        else if (ctl.del)
        begin
            if (pos_ext >= cursor)
            begin
                data_next = right_char;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

[design/leb_peek.sv]
// Output stage: selects the peeked byte from the cell row and holds the result.
// Depends on leb_pkg.
module leb_peek
    import leb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  peek_req_t   req,
    output logic        req_ready,
    input  line_t       line,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // cursor_out[7:0], peek_char[15:8]
);

    logic                valid_reg;
    logic                valid_next;
    logic [CUROUT_W-1:0] cursor_reg;
    logic [CUROUT_W-1:0] cursor_next;
    char_t               char_reg;
    char_t               char_next;

    assign req_ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next  = valid_reg;
        cursor_next = cursor_reg;
        char_next   = char_reg;
        if (req_ready)
        begin
            valid_next = req.valid;
            if (req.valid)
            begin
                cursor_next = CUROUT_W'(req.cursor);
                char_next   = req.hit ? line[req.idx] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        char_reg   <= char_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {char_reg, cursor_reg};

endmodule

[design/line_edit_buffer_unit.sv]
// Line edit buffer top level: row of byte cells, cursor register, output stage.
// Depends on leb_pkg, leb_cell, leb_peek.
// Path: an edit is registered in the cell row, cursor and pending flag, then in the output stage.
// Throughput: one edit per cycle while the output stage is not stalled; shifting cells load from neighbors together.
// Reset: line cleared to zeros and cursor to 0 at once; no output pending.
module line_edit_buffer_unit
    import leb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // char_in[7:0], peek_index[14:8]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // cursor_out[7:0], peek_char[15:8]
);

    logic              in_xfer;
    logic [REQ_W-1:0]  req_type;
    char_t             char_in;
    logic [PEEK_W-1:0] peek_index;
    edit_ctl_t         ctl;
    logic [CUR_W-1:0]  cursor_reg;
    logic [CUR_W-1:0]  cursor_next;
    logic              pend_reg;
    logic              pend_next;
    logic              hit_reg;
    logic [IDX_W-1:0]  idx_reg;
    peek_req_t         req;
    logic              req_ready;
    line_t             line;
    line_t             left_line;
    line_t             right_line;

    assign req_type   = s_axis_tuser;
    assign char_in    = s_axis_tdata[7:0];
    assign peek_index = s_axis_tdata[14:8];

    assign s_axis_tready = !pend_reg || req_ready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        ctl = '0;
        if (in_xfer)
        begin
            unique case (req_type)
                REQ_INSERT:    ctl.ins = 1'b1;
                REQ_BACKSPACE: ctl.bs  = 1'b1;
                REQ_DELETE:    ctl.del = 1'b1;
                REQ_CLEAR:     ctl.clr = 1'b1;
                default:       ctl = '0;
            endcase
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        if (in_xfer)
        begin
            unique case (req_type)
                REQ_BACKSPACE, REQ_LEFT:
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - CUR_W'(1);
                    end
                end
                REQ_RIGHT:
                begin
                    if (cursor_reg != CUR_W'(LINE_LEN))
                    begin
                        cursor_next = cursor_reg + CUR_W'(1);
                    end
                end
                default: cursor_next = cursor_reg;
            endcase
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer)
        begin
            pend_next = 1'b1;
        end
        else if (req_ready)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hit_reg <= (int'(peek_index) < LINE_LEN);
            idx_reg <= IDX_W'(peek_index);
        end
    end

    // neighbor views of the row; ends fill with zero
    assign left_line  = line << CHAR_W;
    assign right_line = line >> CHAR_W;

    genvar k;
    generate
        for (k = 0; k < LINE_LEN; k++)
        begin : g_cell
            leb_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .pos        (IDX_W'(k)),
                .cursor     (cursor_reg),
                .char_in    (char_in),
                .left_char  (left_line[k]),
                .right_char (right_line[k]),
                .data       (line[k])
            );
        end
    endgenerate

    assign req.valid  = pend_reg;
    assign req.hit    = hit_reg;
    assign req.idx    = idx_reg;
    assign req.cursor = cursor_reg;

    leb_peek u_peek (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .req_ready     (req_ready),
        .line          (line),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[dv/tb_line_edit_buffer_unit.sv]
`timescale 1ns / 1ps
// Testbench for line_edit_buffer_unit: streams edit requests with bursty input
// and a patterned output stall, predicts each cursor/peek result and compares
// them in order. Depends on leb_pkg and the line_edit_buffer_unit RTL.
module tb_line_edit_buffer_unit
    import leb_pkg::*;
();

    localparam int RANDOM_EDITS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]  req;
        char_t             ch;
        logic [PEEK_W-1:0] peek;
        bit                drain;
    } edit_item_t;

    typedef struct {
        logic [CUROUT_W-1:0] cursor;
        char_t               peek_char;
    } line_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // char_in[7:0], peek_index[14:8]
    logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // cursor_out[7:0], peek_char[15:8]

    edit_item_t edit_q[$];
    edit_item_t cur_edit;
    line_view_t expected_views[$];

    line_t            model_line = '0;
    logic [CUR_W-1:0] model_cursor = '0;
    int               gen_cursor = 0;

    int n_accepted = 0;
    int n_results  = 0;
    int err_count  = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;

    line_edit_buffer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Remove the byte at pos, pull the tail left, zero the last cell.
    task automatic close_gap(input int pos);
        int k;
        for (k = pos; k < LINE_LEN - 1; k++)
            model_line[k] = model_line[k + 1];
        model_line[LINE_LEN - 1] = '0;
    endtask

    task automatic apply_edit(input edit_item_t it);
        line_view_t v;
        int k;
        case (it.req)
            REQ_INSERT:
                if (model_cursor < LINE_LEN)
                begin
                    for (k = LINE_LEN - 1; k > int'(model_cursor); k--)
                        model_line[k] = model_line[k - 1];
                    model_line[model_cursor] = it.ch;
                end
            REQ_BACKSPACE:
                if (model_cursor != 0)
                begin
                    close_gap(int'(model_cursor) - 1);
                    model_cursor = model_cursor - 1'b1;
                end
            REQ_DELETE:
                if (model_cursor < LINE_LEN)
                    close_gap(int'(model_cursor));
            REQ_LEFT:
                if (model_cursor != 0)
                    model_cursor = model_cursor - 1'b1;
            REQ_RIGHT:
                if (model_cursor < LINE_LEN)
                    model_cursor = model_cursor + 1'b1;
            REQ_CLEAR:
                model_line = '0;
            default: ;
        endcase
        v.cursor = CUROUT_W'(model_cursor);
        v.peek_char = (int'(it.peek) < LINE_LEN) ? model_line[it.peek] : '0;
        expected_views.push_back(v);
    endtask

    function automatic logic [PEEK_W-1:0] near_peek();
        int p;
        if ($urandom_range(0, 1) == 0)
            return PEEK_W'($urandom_range(0, 127));
        p = gen_cursor + int'($urandom_range(0, 4)) - 2;
        if (p < 0)
            p = 0;
        if (p > 127)
            p = 127;
        return PEEK_W'(p);
    endfunction

    task automatic push_edit(input logic [REQ_W-1:0] req, input char_t ch,
                             input logic [PEEK_W-1:0] peek, input bit drain);
        edit_item_t it;
        it.req = req;
        it.ch = ch;
        it.peek = peek;
        it.drain = drain;
        edit_q.push_back(it);
        if ((req == REQ_BACKSPACE || req == REQ_LEFT) && gen_cursor > 0)
            gen_cursor--;
        else if (req == REQ_RIGHT && gen_cursor < LINE_LEN)
            gen_cursor++;
    endtask

    // Driver: bursts of transfers with random gaps, optional drain before an item.
    always @(posedge clk)
    begin : drive
        logic next_valid;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_edit(cur_edit);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (edit_q.size() != 0 &&
                         !(edit_q[0].drain && n_accepted != n_results))
                begin
                    cur_edit = edit_q.pop_front();
                    next_valid = 1'b1;
                    s_axis_tdata <= {1'b0, cur_edit.peek, cur_edit.ch};
                    s_axis_tuser <= cur_edit.req;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // Monitor: checks each result transfer and drives the stall pattern.
    always @(posedge clk)
    begin : monitor
        line_view_t want;
        logic       next_ready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results <= n_results + 1;
                if (expected_views.size() == 0)
                begin
                    err_count++;
                    if (err_count < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (m_axis_tdata[7:0] !== want.cursor)
                    begin
                        err_count++;
                        if (err_count < MAX_REPORTS)
                            $display("%0t: cursor_out expected %0d, actual %0d",
                                     $time, want.cursor, m_axis_tdata[7:0]);
                    end
                    if (m_axis_tdata[15:8] !== want.peek_char)
                    begin
                        err_count++;
                        if (err_count < MAX_REPORTS)
                            $display("%0t: peek_char expected %h, actual %h",
                                     $time, want.peek_char, m_axis_tdata[15:8]);
                    end
                end
            end
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(32, 256);
            end
            rx_left--;
            case (rx_mode)
                0: next_ready = 1'b1;
                1: next_ready = $urandom_range(0, 1);
                2: next_ready = ($urandom_range(0, 3) == 0);
                default: next_ready = cycle_count[1];
            endcase
            m_axis_tready <= next_ready;
        end
    end

    initial
    begin : stimulus
        int i;
        int n;
        int kind;
        logic [REQ_W-1:0] req;

        // Directed: peeks at both ends, cursor limits, inserts, removals, clear.
        push_edit(REQ_IDLE, 8'h00, 7'd0, 1'b0);
        push_edit(REQ_IDLE, 8'hFF, 7'd127, 1'b0);
        push_edit(REQ_LEFT, 8'h00, 7'd0, 1'b0);
        push_edit(REQ_BACKSPACE, 8'h00, 7'd0, 1'b0);
        push_edit(REQ_INSERT, 8'hFF, 7'd0, 1'b0);
        push_edit(REQ_INSERT, 8'h00, 7'd1, 1'b0);
        push_edit(REQ_INSERT, 8'hA5, 7'd2, 1'b0);
        push_edit(REQ_INSERT, 8'h5A, 7'd3, 1'b0);
        push_edit(REQ_DELETE, 8'h00, 7'd0, 1'b0);
        push_edit(REQ_RIGHT, 8'h00, 7'd1, 1'b0);
        push_edit(REQ_RIGHT, 8'h00, 7'd2, 1'b0);
        push_edit(REQ_BACKSPACE, 8'h00, 7'd0, 1'b0);
        push_edit(REQ_INSERT, 8'h81, 7'd1, 1'b0);
        push_edit(REQ_UNUSED, 8'h7F, 7'd1, 1'b0);
        push_edit(REQ_DELETE, 8'h00, 7'd1, 1'b0);
        push_edit(REQ_CLEAR, 8'h00, 7'd0, 1'b0);
        push_edit(REQ_INSERT, 8'h7E, 7'd1, 1'b0);
        push_edit(REQ_IDLE, 8'h00, 7'd127, 1'b1);

        // Walk to end of line and edit there.
        for (i = 0; i < LINE_LEN + 2; i++)
            push_edit(REQ_RIGHT, char_t'($urandom), near_peek(), 1'b0);
        push_edit(REQ_INSERT, char_t'($urandom), 7'd127, 1'b0);
        push_edit(REQ_DELETE, char_t'($urandom), 7'd127, 1'b0);
        push_edit(REQ_RIGHT, char_t'($urandom), 7'd127, 1'b0);
        push_edit(REQ_BACKSPACE, char_t'($urandom), 7'd127, 1'b0);
        push_edit(REQ_INSERT, char_t'($urandom), 7'd127, 1'b0);
        push_edit(REQ_DELETE, char_t'($urandom), 7'd127, 1'b0);

        while (edit_q.size() < RANDOM_EDITS + 18)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 140)
                                                : $urandom_range(1, 24);
                for (i = 0; i < n; i++)
                    push_edit(REQ_INSERT, char_t'($urandom), near_peek(), 1'b0);
            end
            else if (kind == 4)
            begin
                n = $urandom_range(1, 140);
                req = ($urandom_range(0, 1) == 0) ? REQ_LEFT : REQ_RIGHT;
                for (i = 0; i < n; i++)
                    push_edit(req, char_t'($urandom), near_peek(), 1'b0);
            end
            else if (kind <= 7)
            begin
                n = $urandom_range(1, 16);
                for (i = 0; i < n; i++)
                begin
                    req = REQ_W'($urandom_range(0, 7));
                    if (req == REQ_CLEAR && $urandom_range(0, 3) != 0)
                        req = REQ_BACKSPACE;
                    push_edit(req, char_t'($urandom), near_peek(),
                              $urandom_range(0, 399) == 0);
                end
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 20);
                req = ($urandom_range(0, 1) == 0) ? REQ_BACKSPACE : REQ_DELETE;
                for (i = 0; i < n; i++)
                    push_edit(req, char_t'($urandom), near_peek(), 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    push_edit(($urandom_range(0, 1) == 0) ? REQ_IDLE : REQ_UNUSED,
                              char_t'($urandom), PEEK_W'($urandom), 1'b0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (edit_q.size() != 0 || s_axis_tvalid || n_results != n_accepted)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (err_count == 0 && expected_views.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
design/leb_pkg.sv
design/leb_cell.sv
design/leb_peek.sv
design/line_edit_buffer_unit.sv
dv/tb_line_edit_buffer_unit.sv
